// ----- rtl/core/named_resource_counter_table_defines.svh -----
// Assertion macros for the named resource counter table.
`ifndef NAMED_RESOURCE_COUNTER_TABLE_DEFINES_SVH
`define NAMED_RESOURCE_COUNTER_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define NRCT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nrct: implication check failed");
// Check that cons holds in the cycle after ante.
`define NRCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nrct: next-cycle check failed");
`else
`define NRCT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NRCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/nrct_pkg.sv -----
// Shared types, codes and constants of the named resource counter table.
package nrct_pkg;

   localparam int DEF_TABLE_ENTRIES = 16;
   localparam int DEF_KEY_BITS      = 64;

   localparam int COUNT_BITS = 16;
   localparam int SEM_BITS   = 17;

   localparam logic signed [SEM_BITS-1:0] SEM_MAX = 17'h0FFFF;
   localparam logic signed [SEM_BITS-1:0] SEM_MIN = 17'h10000;

   // request kinds
   localparam logic [2:0] KIND_CLEAR   = 3'd0;
   localparam logic [2:0] KIND_ADD     = 3'd1;
   localparam logic [2:0] KIND_RELEASE = 3'd2;
   localparam logic [2:0] KIND_ACQUIRE = 3'd3;
   localparam logic [2:0] KIND_QUERY   = 3'd4;

   // response status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   typedef enum logic [1:0] {
      CNT_OP_READ,
      CNT_OP_RELEASE,
      CNT_OP_ACQUIRE
   } cnt_op_type;

   typedef struct packed {
      logic       start;
      cnt_op_type op;
      logic       xfer;
   } cnt_cmd_type;

   typedef struct packed {
      logic done;
      logic hit;
   } srch_stat_type;

   typedef struct packed {
      logic        [COUNT_BITS-1:0] total;
      logic        [COUNT_BITS-1:0] avail;
      logic signed [SEM_BITS-1:0]   sem;
   } cnt_entry_type;

endpackage

// ----- rtl/core/nrct_key_search.sv -----
// Key memory with a sequential first-match search over the used entries.
module nrct_key_search #(
   parameter int TABLE_ENTRIES = nrct_pkg::DEF_TABLE_ENTRIES,
   parameter int KEY_BITS      = nrct_pkg::DEF_KEY_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx,
   input  logic [KEY_BITS-1:0]              wr_key,
   input  logic                             srch_start,
   input  logic [KEY_BITS-1:0]              srch_key,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0] srch_count,
   output nrct_pkg::srch_stat_type          srch_st,
   output logic [$clog2(TABLE_ENTRIES)-1:0] srch_idx
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic [KEY_BITS-1:0] key_mem [0:TABLE_ENTRIES-1];

   logic                issue_ff;
   logic [CNT_W-1:0]    addr_ff;
   logic                cmp_vld_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic [KEY_BITS-1:0] rd_key_ff;

   logic match;
   logic last;
   logic done;
   logic [CNT_W-1:0] addr_nxt;

   // compare the entry read last cycle
   assign match    = rd_key_ff == srch_key;
   assign last     = CNT_W'(CNT_W'(cmp_idx_ff) + CNT_W'(1)) == srch_count;
   assign done     = cmp_vld_ff && (match || last);
   assign addr_nxt = CNT_W'(addr_ff + CNT_W'(1));

   // advance the read address, stop at a hit or past the last used entry
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff   <= 1'b0;
         addr_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else if (srch_start) begin
         issue_ff   <= 1'b1;
         addr_ff    <= '0;
         cmp_vld_ff <= 1'b0;
      end else if (done) begin
         issue_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= issue_ff;
         if (issue_ff) begin
            addr_ff <= addr_nxt;
            if (addr_nxt == srch_count) begin
               issue_ff <= 1'b0;
            end
         end
      end
   end

   // write on add, read one entry a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_idx] <= wr_key;
      end
      rd_key_ff  <= key_mem[addr_ff[IDX_W-1:0]];
      cmp_idx_ff <= addr_ff[IDX_W-1:0];
   end

   assign srch_st.done = done;
   assign srch_st.hit  = match;
   assign srch_idx     = cmp_idx_ff;

endmodule

// ----- rtl/core/nrct_cnt_unit.sv -----
// Counter memory with read-modify-write for release, acquire and query.
module nrct_cnt_unit #(
   parameter int TABLE_ENTRIES = nrct_pkg::DEF_TABLE_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx,
   input  nrct_pkg::cnt_entry_type          wr_entry,
   input  nrct_pkg::cnt_cmd_type            cmd,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] cmd_idx,
   output logic                             res_done,
   output nrct_pkg::cnt_entry_type          res_entry,
   output logic                             res_granted
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   nrct_pkg::cnt_entry_type cnt_mem [0:TABLE_ENTRIES-1];

   logic                    pend_ff;
   nrct_pkg::cnt_op_type    op_ff;
   logic                    xfer_ff;
   logic [IDX_W-1:0]        idx_ff;
   nrct_pkg::cnt_entry_type cur_ff;

   nrct_pkg::cnt_entry_type nxt;
   logic                    grant;

   // work out the updated counts from the entry read
   always_comb begin
      nxt   = cur_ff;
      grant = 1'b0;
      case (op_ff)
         nrct_pkg::CNT_OP_RELEASE: begin
            if (xfer_ff && (cur_ff.avail < cur_ff.total)) begin
               nxt.avail = nrct_pkg::COUNT_BITS'(cur_ff.avail + 16'd1);
            end
            if (cur_ff.sem != nrct_pkg::SEM_MAX) begin
               nxt.sem = nrct_pkg::SEM_BITS'(cur_ff.sem + 17'sd1);
            end
         end
         nrct_pkg::CNT_OP_ACQUIRE: begin
            if (xfer_ff && (cur_ff.avail != '0)) begin
               nxt.avail = nrct_pkg::COUNT_BITS'(cur_ff.avail - 16'd1);
               grant     = 1'b1;
            end
            if (cur_ff.sem != nrct_pkg::SEM_MIN) begin
               nxt.sem = nrct_pkg::SEM_BITS'(cur_ff.sem - 17'sd1);
            end
         end
         default: begin
            nxt = cur_ff;
         end
      endcase
   end

   // hold the command while its read is in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.start;
      end
      if (cmd.start) begin
         op_ff   <= cmd.op;
         xfer_ff <= cmd.xfer;
         idx_ff  <= cmd_idx;
      end
   end

   // write on add or write back the update, read on command
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_idx] <= wr_entry;
      end else if (pend_ff) begin
         cnt_mem[idx_ff] <= nxt;
      end
      if (cmd.start) begin
         cur_ff <= cnt_mem[cmd_idx];
      end
   end

   assign res_done    = pend_ff;
   assign res_entry   = nxt;
   assign res_granted = grant;

endmodule

// ----- rtl/core/named_resource_counter_table.sv -----
// Top level: request sequencing, entry count and response beat of the table.
// Clear, add, full table and unused kinds: busy stays low, response next cycle.
// Lookup by slot or query: ST_CNT_ISSUE and ST_CNT_WAIT for the counter memory read and update, then the response.
// Lookup by key: ST_SRCH_ISSUE and ST_SRCH_WAIT, one key memory read per cycle, then the counter steps.
// One item at a time; rsp_strobe marks each response beat for one cycle.
// Synchronous reset empties the table; memory contents are not cleared.
`include "named_resource_counter_table_defines.svh"
module named_resource_counter_table #(
   parameter int TABLE_ENTRIES = nrct_pkg::DEF_TABLE_ENTRIES,
   parameter int KEY_BITS      = nrct_pkg::DEF_KEY_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic               req_by_position,
   input  logic [63:0]        req_name_key,
   input  logic [3:0]         req_slot,
   input  logic [15:0]        req_instances,
   input  logic               req_with_transfer,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_found_slot,
   output logic [15:0]        rsp_available_now,
   output logic [15:0]        rsp_total_now,
   output logic signed [16:0] rsp_semaphore_now,
   output logic               rsp_granted,
   output logic [4:0]         rsp_entries_used
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int W4    = (CNT_W > 4) ? CNT_W : 4;
   localparam int EU_W  = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH_ISSUE,
      ST_SRCH_WAIT,
      ST_CNT_ISSUE,
      ST_CNT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [2:0]          kind_ff, kind_in;
   logic                xfer_ff, xfer_in;
   logic [KEY_BITS-1:0] key_ff, key_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [3:0]         rsp_slot_ff, rsp_slot_in;
   logic [15:0]        rsp_avail_ff, rsp_avail_in;
   logic [15:0]        rsp_total_ff, rsp_total_in;
   logic signed [16:0] rsp_sem_ff, rsp_sem_in;
   logic               rsp_granted_ff, rsp_granted_in;
   logic [4:0]         rsp_used_ff, rsp_used_in;

   logic                    req_accept;
   logic                    table_full;
   logic                    add_wr;
   logic [CNT_W-1:0]        used_inc;
   logic [W4-1:0]           used_w4;
   logic [W4-1:0]           slot_w4;
   logic [W4-1:0]           idx_w4;
   logic [EU_W-1:0]         used_eu;
   logic [EU_W-1:0]         used_inc_eu;
   nrct_pkg::cnt_entry_type add_entry;
   nrct_pkg::cnt_cmd_type   cnt_cmd;
   nrct_pkg::srch_stat_type srch_st;
   logic [IDX_W-1:0]        srch_idx;
   logic                    cnt_done;
   nrct_pkg::cnt_entry_type cnt_entry;
   logic                    cnt_granted;

   assign busy        = state_ff != ST_IDLE;
   assign req_accept  = start && !busy;
   assign table_full  = used_ff == FULL_COUNT;
   assign add_wr      = req_accept && (req_kind == nrct_pkg::KIND_ADD) && !table_full;
   assign used_inc    = CNT_W'(used_ff + CNT_W'(1));
   assign used_w4     = W4'(used_ff);
   assign slot_w4     = W4'(req_slot);
   assign idx_w4      = W4'(idx_ff);
   assign used_eu     = EU_W'(used_ff);
   assign used_inc_eu = EU_W'(used_inc);

   assign add_entry.total = req_instances;
   assign add_entry.avail = req_instances;
   assign add_entry.sem   = $signed({1'b0, req_instances});

   // drive the counter command from the sequencer state
   always_comb begin
      cnt_cmd.start = state_ff == ST_CNT_ISSUE;
      cnt_cmd.xfer  = xfer_ff;
      case (kind_ff)
         nrct_pkg::KIND_RELEASE: cnt_cmd.op = nrct_pkg::CNT_OP_RELEASE;
         nrct_pkg::KIND_ACQUIRE: cnt_cmd.op = nrct_pkg::CNT_OP_ACQUIRE;
         default:                cnt_cmd.op = nrct_pkg::CNT_OP_READ;
      endcase
   end

   nrct_key_search #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS)
   ) u_key_search (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (add_wr),
      .wr_idx     (used_ff[IDX_W-1:0]),
      .wr_key     (req_name_key[KEY_BITS-1:0]),
      .srch_start (state_ff == ST_SRCH_ISSUE),
      .srch_key   (key_ff),
      .srch_count (used_ff),
      .srch_st    (srch_st),
      .srch_idx   (srch_idx)
   );

   nrct_cnt_unit #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_cnt_unit (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (add_wr),
      .wr_idx      (used_ff[IDX_W-1:0]),
      .wr_entry    (add_entry),
      .cmd         (cnt_cmd),
      .cmd_idx     (idx_ff),
      .res_done    (cnt_done),
      .res_entry   (cnt_entry),
      .res_granted (cnt_granted)
   );

   // sequence the request and build the response beat
   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      idx_in         = idx_ff;
      kind_in        = kind_ff;
      xfer_in        = xfer_ff;
      key_in         = key_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = nrct_pkg::STAT_MISS;
      rsp_slot_in    = '0;
      rsp_avail_in   = '0;
      rsp_total_in   = '0;
      rsp_sem_in     = '0;
      rsp_granted_in = 1'b0;
      rsp_used_in    = used_eu[4:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in = req_kind;
               xfer_in = req_with_transfer;
               key_in  = req_name_key[KEY_BITS-1:0];
               case (req_kind)
                  nrct_pkg::KIND_CLEAR: begin
                     used_in       = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = nrct_pkg::STAT_OK;
                     rsp_used_in   = '0;
                  end
                  nrct_pkg::KIND_ADD: begin
                     rsp_strobe_in = 1'b1;
                     if (table_full) begin
                        rsp_status_in = nrct_pkg::STAT_FULL;
                     end else begin
                        used_in       = used_inc;
                        rsp_status_in = nrct_pkg::STAT_OK;
                        rsp_slot_in   = used_w4[3:0];
                        rsp_avail_in  = req_instances;
                        rsp_total_in  = req_instances;
                        rsp_sem_in    = add_entry.sem;
                        rsp_used_in   = used_inc_eu[4:0];
                     end
                  end
                  nrct_pkg::KIND_RELEASE, nrct_pkg::KIND_ACQUIRE, nrct_pkg::KIND_QUERY: begin
                     if ((req_kind == nrct_pkg::KIND_QUERY) || req_by_position) begin
                        if (slot_w4 < used_w4) begin
                           idx_in   = slot_w4[IDX_W-1:0];
                           state_in = ST_CNT_ISSUE;
                        end else begin
                           rsp_strobe_in = 1'b1;
                        end
                     end else if (used_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = ST_SRCH_ISSUE;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SRCH_ISSUE: begin
            state_in = ST_SRCH_WAIT;
         end
         ST_SRCH_WAIT: begin
            if (srch_st.done) begin
               if (srch_st.hit) begin
                  idx_in   = srch_idx;
                  state_in = ST_CNT_ISSUE;
               end else begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_CNT_ISSUE: begin
            state_in = ST_CNT_WAIT;
         end
         ST_CNT_WAIT: begin
            if (cnt_done) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = nrct_pkg::STAT_OK;
               rsp_slot_in    = idx_w4[3:0];
               rsp_avail_in   = cnt_entry.avail;
               rsp_total_in   = cnt_entry.total;
               rsp_sem_in     = cnt_entry.sem;
               rsp_granted_in = cnt_granted;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state, entry count and the response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff         <= idx_in;
      kind_ff        <= kind_in;
      xfer_ff        <= xfer_in;
      key_ff         <= key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_avail_ff   <= rsp_avail_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_sem_ff     <= rsp_sem_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_slot    = rsp_slot_ff;
   assign rsp_available_now = rsp_avail_ff;
   assign rsp_total_now     = rsp_total_ff;
   assign rsp_semaphore_now = rsp_sem_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_entries_used  = rsp_used_ff;

   // a response beat only follows an accepted request or a busy cycle
   `NRCT_ASSERT_NEXT(a_rsp_has_cause, clock, reset, !req_accept && (state_ff == ST_IDLE), !rsp_strobe_ff)
   // the entry count never passes the table size
   `NRCT_ASSERT_IMPLY(a_used_bound, clock, reset, 1'b1, used_ff <= FULL_COUNT)
   // a grant is only reported with an ok status
   `NRCT_ASSERT_IMPLY(a_grant_ok, clock, reset, rsp_strobe_ff && rsp_granted_ff, rsp_status_ff == nrct_pkg::STAT_OK)
   // the key search only finishes while the sequencer waits for it
   `NRCT_ASSERT_IMPLY(a_srch_done_wait, clock, reset, srch_st.done, state_ff == ST_SRCH_WAIT)

endmodule

// ----- test/named_resource_counter_table_checker.sv -----
// Checker for the resource counter table: predicts every response beat and compares it.
`timescale 1ns / 1ps
module named_resource_counter_table_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_kind,
   input  logic               req_by_position,
   input  logic [63:0]        req_name_key,
   input  logic [3:0]         req_slot,
   input  logic [15:0]        req_instances,
   input  logic               req_with_transfer,
   input  logic               rsp_strobe,
   input  logic [1:0]         rsp_status,
   input  logic [3:0]         rsp_found_slot,
   input  logic [15:0]        rsp_available_now,
   input  logic [15:0]        rsp_total_now,
   input  logic signed [16:0] rsp_semaphore_now,
   input  logic               rsp_granted,
   input  logic [4:0]         rsp_entries_used,
   output int                 mismatches,
   output int                 outstanding
);
   import nrct_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         slot;
      logic [15:0]        avail;
      logic [15:0]        total;
      logic signed [16:0] sem;
      logic               granted;
      logic [4:0]         used;
   } table_reply_t;

   // shadow copy of the table
   logic [63:0]        tab_key   [DEF_TABLE_ENTRIES];
   logic [15:0]        tab_total [DEF_TABLE_ENTRIES];
   logic [15:0]        tab_avail [DEF_TABLE_ENTRIES];
   logic signed [16:0] tab_sem   [DEF_TABLE_ENTRIES];
   int                 fill_count;

   table_reply_t replies_due[$];

   // Apply one request to the shadow table and work out its response.
   task automatic predict_reply(input logic [2:0] kind, input logic by_pos,
         input logic [63:0] key, input logic [3:0] slot, input logic [15:0] inst,
         input logic xfer, output table_reply_t r);
      int   idx;
      logic hit;
      r   = '0;
      idx = 0;
      hit = 1'b0;
      case (kind)
         KIND_CLEAR: fill_count = 0;
         KIND_ADD: begin
            if (fill_count >= DEF_TABLE_ENTRIES) begin
               r.status = STAT_FULL;
            end else begin
               idx            = fill_count;
               tab_key[idx]   = key;
               tab_total[idx] = inst;
               tab_avail[idx] = inst;
               tab_sem[idx]   = $signed({1'b0, inst});
               fill_count     = fill_count + 1;
               hit            = 1'b1;
            end
         end
         KIND_RELEASE, KIND_ACQUIRE, KIND_QUERY: begin
            // query always goes by slot; the others by slot or by first key match
            if (kind == KIND_QUERY || by_pos) begin
               if (int'(slot) < fill_count) begin
                  idx = slot;
                  hit = 1'b1;
               end
            end else begin
               for (int i = 0; i < fill_count; i++) begin
                  if (!hit && tab_key[i] == key) begin
                     idx = i;
                     hit = 1'b1;
                  end
               end
            end
            if (!hit) begin
               r.status = STAT_MISS;
            end else if (kind == KIND_RELEASE) begin
               if (xfer && tab_avail[idx] < tab_total[idx])
                  tab_avail[idx] = tab_avail[idx] + 16'd1;
               if (tab_sem[idx] < SEM_MAX)
                  tab_sem[idx] = tab_sem[idx] + 17'sd1;
            end else if (kind == KIND_ACQUIRE) begin
               if (xfer && tab_avail[idx] != 16'd0) begin
                  tab_avail[idx] = tab_avail[idx] - 16'd1;
                  r.granted      = 1'b1;
               end
               if (tab_sem[idx] > SEM_MIN)
                  tab_sem[idx] = tab_sem[idx] - 17'sd1;
            end
         end
         default: r.status = STAT_MISS;
      endcase
      if (hit) begin
         r.slot  = 4'(idx);
         r.avail = tab_avail[idx];
         r.total = tab_total[idx];
         r.sem   = tab_sem[idx];
      end
      r.used = 5'(fill_count);
   endtask

   function automatic int field_differs(input string fname, input longint want,
         input longint got);
      if (want == got)
         return 0;
      $error("%s: expected %0d, got %0d", fname, want, got);
      return 1;
   endfunction

   // Predict on each accepted request, compare on each response beat.
   always @(posedge clock) begin
      table_reply_t fresh;
      table_reply_t want;
      int           bad;
      bad = 0;
      if (reset) begin
         fill_count = 0;
         replies_due.delete();
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         if (start && !busy) begin
            predict_reply(req_kind, req_by_position, req_name_key, req_slot,
                          req_instances, req_with_transfer, fresh);
            replies_due.push_back(fresh);
         end
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               $error("response beat with no request outstanding");
               bad = 1;
            end else begin
               want = replies_due.pop_front();
               bad += field_differs("status", want.status, rsp_status);
               bad += field_differs("found_slot", want.slot, rsp_found_slot);
               bad += field_differs("available_now", want.avail, rsp_available_now);
               bad += field_differs("total_now", want.total, rsp_total_now);
               bad += field_differs("semaphore_now", want.sem, rsp_semaphore_now);
               bad += field_differs("granted", want.granted, rsp_granted);
               bad += field_differs("entries_used", want.used, rsp_entries_used);
            end
         end
         mismatches  <= mismatches + bad;
         outstanding <= replies_due.size();
      end
   end

endmodule

// ----- test/named_resource_counter_table_tb.sv -----
// Testbench top: clock, reset and request stimulus for the resource counter table.
`timescale 1ns / 1ps
module named_resource_counter_table_tb;
   import nrct_pkg::*;

   localparam int          CYCLE_LIMIT    = 2_000_000;
   localparam int          DRAIN_ACQUIRES = 8;
   localparam int          PHASE_ITEMS    = 285;
   localparam logic [2:0]  KIND_SPARE_LO  = 3'd5;
   localparam logic [2:0]  KIND_SPARE_HI  = 3'd7;
   localparam logic [63:0] KEY_ONES       = '1;
   localparam logic [15:0] INST_MAX       = '1;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_kind;
   logic               req_by_position;
   logic [63:0]        req_name_key;
   logic [3:0]         req_slot;
   logic [15:0]        req_instances;
   logic               req_with_transfer;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic [3:0]         rsp_found_slot;
   logic [15:0]        rsp_available_now;
   logic [15:0]        rsp_total_now;
   logic signed [16:0] rsp_semaphore_now;
   logic               rsp_granted;
   logic [4:0]         rsp_entries_used;
   int                 mismatches;
   int                 outstanding;
   int                 cycle_count;
   logic [63:0]        name_pool [8];

   named_resource_counter_table DUT (.*);

   named_resource_counter_table_checker checker_inst (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Abort a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("named_resource_counter_table_tb: done, errors");
         $finish;
      end
   end

   // Present one request and hold it until the beat is taken.
   task automatic issue(input logic [2:0] kind, input logic by_pos, input logic [63:0] key,
         input logic [3:0] slot, input logic [15:0] inst, input logic xfer);
      req_kind          <= kind;
      req_by_position   <= by_pos;
      req_name_key      <= key;
      req_slot          <= slot;
      req_instances     <= inst;
      req_with_transfer <= xfer;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start for a random gap, pct times in a hundred.
   task automatic pause(input int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Hold off until every response has come back.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly well-formed traffic on a small pool of names, some noise.
   task automatic random_request();
      int          pick;
      int          size_pick;
      logic [2:0]  kind;
      logic [63:0] key;
      logic [15:0] inst;
      pick = $urandom_range(99);
      if (pick < 1)
         kind = KIND_CLEAR;
      else if (pick < 27)
         kind = KIND_ADD;
      else if (pick < 52)
         kind = KIND_RELEASE;
      else if (pick < 82)
         kind = KIND_ACQUIRE;
      else if (pick < 94)
         kind = KIND_QUERY;
      else
         kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      key = ($urandom_range(99) < 85) ? name_pool[$urandom_range(7)] : {$urandom, $urandom};
      size_pick = $urandom_range(9);
      if (size_pick < 6)
         inst = 16'($urandom_range(3));
      else if (size_pick < 9)
         inst = 16'($urandom);
      else
         inst = INST_MAX;
      issue(kind, $urandom_range(99) < 35, key, 4'($urandom_range(15)), inst,
            $urandom_range(99) < 70);
   endtask

   initial begin
      int n;
      int phase;
      int pct;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_kind          <= KIND_CLEAR;
      req_by_position   <= 1'b0;
      req_name_key      <= '0;
      req_slot          <= '0;
      req_instances     <= '0;
      req_with_transfer <= 1'b0;
      name_pool[0] = '0;
      name_pool[1] = KEY_ONES;
      for (n = 2; n < 8; n++)
         name_pool[n] = {$urandom, $urandom};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // lookups on an empty table
      issue(KIND_QUERY, 1'b0, '0, 4'd0, '0, 1'b0);
      issue(KIND_ACQUIRE, 1'b0, '0, 4'd0, '0, 1'b1);
      // extremes of instances and key, duplicate name
      issue(KIND_ADD, 1'b0, '0, 4'd0, 16'd0, 1'b0);
      issue(KIND_ADD, 1'b1, KEY_ONES, 4'hF, INST_MAX, 1'b1);
      issue(KIND_ADD, 1'b0, KEY_ONES, 4'd0, 16'd1, 1'b0);
      // duplicate name resolves to the lower slot
      issue(KIND_ACQUIRE, 1'b0, KEY_ONES, 4'd0, '0, 1'b1);
      // nothing available: no grant, semaphore goes negative
      issue(KIND_ACQUIRE, 1'b0, '0, 4'd0, '0, 1'b1);
      // release back to total, then semaphore saturates high
      issue(KIND_RELEASE, 1'b0, KEY_ONES, 4'd0, '0, 1'b1);
      issue(KIND_RELEASE, 1'b0, KEY_ONES, 4'd0, '0, 1'b1);
      issue(KIND_RELEASE, 1'b0, KEY_ONES, 4'd0, '0, 1'b0);
      // by slot: grant, then exhausted, then release without transfer
      issue(KIND_ACQUIRE, 1'b1, '0, 4'd2, INST_MAX, 1'b1);
      issue(KIND_ACQUIRE, 1'b1, '0, 4'd2, '0, 1'b1);
      issue(KIND_RELEASE, 1'b1, '0, 4'd2, '0, 1'b0);
      // slots past the used entries, a query that goes by slot despite a key, unknown name
      issue(KIND_ACQUIRE, 1'b1, '0, 4'd9, '0, 1'b1);
      issue(KIND_QUERY, 1'b0, KEY_ONES, 4'd1, '0, 1'b0);
      issue(KIND_QUERY, 1'b1, '0, 4'hF, '0, 1'b0);
      issue(KIND_RELEASE, 1'b0, 64'h123, 4'd0, '0, 1'b1);
      // unused kinds
      for (n = KIND_SPARE_LO; n <= KIND_SPARE_HI; n++)
         issue(3'(n), 1'($urandom), {$urandom, $urandom}, 4'($urandom), 16'($urandom),
               1'($urandom));
      issue(KIND_CLEAR, 1'b1, KEY_ONES, 4'hF, INST_MAX, 1'b1);
      issue(KIND_QUERY, 1'b1, '0, 4'd0, '0, 1'b0);

      // fill the table, overflow it, then run an empty entry's semaphore negative
      issue(KIND_ADD, 1'b0, name_pool[2], 4'd0, 16'd0, 1'b0);
      for (n = 1; n < DEF_TABLE_ENTRIES; n++)
         issue(KIND_ADD, 1'b0, {$urandom, $urandom}, 4'd0, 16'($urandom), 1'b0);
      issue(KIND_ADD, 1'b0, name_pool[3], 4'd0, 16'd5, 1'b0);
      for (n = 0; n < DRAIN_ACQUIRES; n++)
         issue(KIND_ACQUIRE, 1'b1, '0, 4'd0, '0, 1'($urandom));
      issue(KIND_RELEASE, 1'b1, '0, 4'd0, '0, 1'b1);
      issue(KIND_CLEAR, 1'b0, '0, 4'd0, '0, 1'b0);

      // random traffic: light sender gaps, heavy gaps, then none
      for (phase = 0; phase < 3; phase++) begin
         pct = (phase == 0) ? 21 : (phase == 1) ? 64 : 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            random_request();
            if (n == PHASE_ITEMS / 2)
               settle();
            else
               pause(pct);
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("named_resource_counter_table_tb: done, clean");
      else
         $display("named_resource_counter_table_tb: done, errors");
      $finish;
   end

endmodule
